// File: rtl/core/sobb_pkg.sv
package sobb_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int AXIS_WIDTH  = 16;
    localparam int TIME_FRAC   = 16;
    localparam int NUM_AXES    = 3;
    localparam int NUM_LANES   = 2 * NUM_AXES;
    localparam int CFG_W       = 3 * COORD_WIDTH;
    localparam int AXIS_REG_W  = 3 * AXIS_WIDTH;

    // offset from center, segment delta, products and dot products
    localparam int OFS_W  = COORD_WIDTH + 1;
    localparam int DEL_W  = COORD_WIDTH + 2;
    localparam int PROD_W = DEL_W + AXIS_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int EXT_W  = COORD_WIDTH + 1;
    localparam int NUM_W  = SUM_W + 1;
    localparam int MAG_W  = NUM_W;

    // quotient: one integer bit plus saturation value 2.0
    localparam int Q_W       = TIME_FRAC + 2;
    localparam int TIME_W    = Q_W + 1;
    localparam int DIV_STEPS = TIME_FRAC + 1;

    localparam logic [MAG_W-1:0] PAR_EPS =
        MAG_W'((64'd1 << (AXIS_WIDTH + 6)) / 64'd1000000);
    localparam logic [Q_W-1:0] TIME_SAT_Q = Q_W'(64'd2 << TIME_FRAC);
    localparam logic signed [TIME_W-1:0] TIME_ONE = TIME_W'(64'd1 << TIME_FRAC);
    localparam logic [AXIS_WIDTH-1:0] AXIS_ONE = AXIS_WIDTH'(64'd1 << (AXIS_WIDTH - 2));

    typedef enum logic [2:0] {
        CFG_CENTER   = 3'd0,
        CFG_FORWARD  = 3'd1,
        CFG_UP       = 3'd2,
        CFG_LEFT     = 3'd3,
        CFG_HALF     = 3'd4,
        CFG_EXPAND   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] d;
        logic [EXT_W-1:0]        ext;
    } proj_t;

    typedef struct packed {
        logic           neg;
        logic           sat;
        logic [Q_W-1:0] q;
    } quot_t;

    typedef struct packed {
        logic par;
        logic par_ok;
    } slab_flag_t;

endpackage

// File: rtl/core/segment_obb_slab_test_core.sv
// Segment versus oriented box test by the slab method. Each input word is one
// segment (start and end point, signed Q11.8); each output word is one hit
// flag, set when any part of the segment lies in the box widened by its
// per-axis expansion. The block is fully pipelined: one segment per clock is
// accepted while the output is not stalled, and its hit word passes through
// 23 register stages, the first loaded at the accepting edge: three
// projection stages, one divider prep stage, the 17 quotient-bit stages of
// the six parallel time dividers and two merge stages.
// Each stage holds its word under backpressure, so idle stages are filled
// before the input stalls. Box registers are written through cfg_* and must
// only change while no segment is in flight.
module segment_obb_slab_test_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [119:0]                   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit, then zero padding
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [sobb_pkg::CFG_W-1:0]     cfg_wdata
);
    import sobb_pkg::*;

    logic [CFG_W-1:0]      center_reg;
    logic [AXIS_REG_W-1:0] fwd_reg, up_reg, left_reg;
    logic [CFG_W-1:0]      half_reg, expand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            fwd_reg    <= AXIS_REG_W'(AXIS_ONE);
            up_reg     <= AXIS_REG_W'(AXIS_ONE) << AXIS_WIDTH;
            left_reg   <= AXIS_REG_W'(AXIS_ONE) << (2 * AXIS_WIDTH);
            half_reg   <= '0;
            expand_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER:  center_reg <= cfg_wdata;
                CFG_FORWARD: fwd_reg    <= cfg_wdata[AXIS_REG_W-1:0];
                CFG_UP:      up_reg     <= cfg_wdata[AXIS_REG_W-1:0];
                CFG_LEFT:    left_reg   <= cfg_wdata[AXIS_REG_W-1:0];
                CFG_HALF:    half_reg   <= cfg_wdata;
                CFG_EXPAND:  expand_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [2:0][2:0][AXIS_WIDTH-1:0] axes;
    assign axes[0] = fwd_reg;
    assign axes[1] = up_reg;
    assign axes[2] = left_reg;

    logic               p_valid, p_ready;
    proj_t [2:0]        p_proj;
    logic               d_valid, d_ready;
    quot_t [5:0]        d_quot;
    slab_flag_t [2:0]   d_flag;
    logic               hit;

    sobb_proj u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pts       (s_tdata),
        .center    (center_reg),
        .axes      (axes),
        .half      (half_reg),
        .expand    (expand_reg),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_proj  (p_proj)
    );

    sobb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_proj   (p_proj),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_quot  (d_quot),
        .out_flag  (d_flag)
    );

    sobb_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_quot   (d_quot),
        .in_flag   (d_flag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit)
    );

    assign m_tdata = {7'b0, hit};

endmodule

// File: rtl/core/sobb_proj.sv
module sobb_proj (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [5:0][sobb_pkg::COORD_WIDTH-1:0]                 pts,
    input  logic [2:0][sobb_pkg::COORD_WIDTH-1:0]                 center,
    input  logic [2:0][2:0][sobb_pkg::AXIS_WIDTH-1:0]             axes,
    input  logic [2:0][sobb_pkg::COORD_WIDTH-1:0]                 half,
    input  logic [2:0][sobb_pkg::COORD_WIDTH-1:0]                 expand,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output sobb_pkg::proj_t [2:0]                                 out_proj
);
    import sobb_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    logic signed [OFS_W-1:0]  so_reg  [3];
    logic signed [DEL_W-1:0]  del_reg [3];
    logic signed [PROD_W-1:0] sp_reg  [3][3];
    logic signed [PROD_W-1:0] dp_reg  [3][3];
    proj_t [2:0]              proj_reg;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v3_reg;
    assign out_proj  = proj_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // offsets from the box center and segment delta
    always_ff @(posedge aclk) begin
        if (adv1) begin
            for (int c = 0; c < 3; c++) begin
                so_reg[c]  <= OFS_W'($signed(pts[c])) - OFS_W'($signed(center[c]));
                del_reg[c] <= DEL_W'($signed(pts[c+3])) - DEL_W'($signed(pts[c]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    sp_reg[k][c] <= PROD_W'(so_reg[c]) * PROD_W'($signed(axes[k][c]));
                    dp_reg[k][c] <= PROD_W'(del_reg[c]) * PROD_W'($signed(axes[k][c]));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            for (int k = 0; k < 3; k++) begin
                proj_reg[k].s <= SUM_W'(sp_reg[k][0]) + SUM_W'(sp_reg[k][1])
                                 + SUM_W'(sp_reg[k][2]);
                proj_reg[k].d <= SUM_W'(dp_reg[k][0]) + SUM_W'(dp_reg[k][1])
                                 + SUM_W'(dp_reg[k][2]);
                proj_reg[k].ext <= EXT_W'(half[k]) + EXT_W'(expand[k]);
            end
        end
    end

endmodule

// File: rtl/core/sobb_div.sv
module sobb_div (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  sobb_pkg::proj_t [2:0]                   in_proj,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output sobb_pkg::quot_t [5:0]                   out_quot,
    output sobb_pkg::slab_flag_t [2:0]              out_flag
);
    import sobb_pkg::*;

    localparam int LAST = DIV_STEPS;

    logic                    v_reg  [LAST+1];
    logic                    adv    [LAST+1];
    logic [MAG_W-1:0]        r_reg  [LAST+1][NUM_LANES];
    logic [MAG_W-1:0]        ud_reg [LAST+1][NUM_LANES];
    logic [Q_W-1:0]          q_reg  [LAST+1][NUM_LANES];
    logic                    neg_reg[LAST+1][NUM_LANES];
    logic                    sat_reg[LAST+1][NUM_LANES];
    slab_flag_t [2:0]        flag_reg [LAST+1];

    logic [MAG_W-1:0]        r_next [LAST+1][NUM_LANES];
    logic [Q_W-1:0]          q_next [LAST+1][NUM_LANES];

    // per-stage handshake, collapses bubbles
    always_comb begin
        adv[LAST] = !v_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end
    assign in_ready  = adv[0];
    assign out_valid = v_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAST; i++) v_reg[i] <= 1'b0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int i = 1; i <= LAST; i++) begin
                if (adv[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // prep: numerators, magnitudes, parallel test, saturation test
    always_comb begin
        logic signed [NUM_W-1:0] ext_sh;
        logic signed [NUM_W-1:0] s_w;
        logic signed [NUM_W-1:0] n_in;
        logic signed [NUM_W-1:0] n_out;
        for (int l = 0; l < NUM_LANES; l++) begin
            r_next[0][l] = '0;
            q_next[0][l] = '0;
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            ext_sh = $signed(NUM_W'(in_proj[k].ext) << (AXIS_WIDTH - 2));
            s_w    = NUM_W'(in_proj[k].s);
            n_in   = -ext_sh - s_w;
            n_out  = ext_sh - s_w;
            r_next[0][2*k]   = n_in[NUM_W-1]  ? MAG_W'(-n_in)  : MAG_W'(n_in);
            r_next[0][2*k+1] = n_out[NUM_W-1] ? MAG_W'(-n_out) : MAG_W'(n_out);
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [NUM_W-1:0] ext_sh;
        logic signed [NUM_W-1:0] s_w;
        logic signed [NUM_W-1:0] d_w;
        logic [MAG_W-1:0]        ud;
        if (adv[0]) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                ext_sh = $signed(NUM_W'(in_proj[k].ext) << (AXIS_WIDTH - 2));
                s_w    = NUM_W'(in_proj[k].s);
                d_w    = NUM_W'(in_proj[k].d);
                ud     = d_w[NUM_W-1] ? MAG_W'(-d_w) : MAG_W'(d_w);
                flag_reg[0][k].par    <= (ud <= PAR_EPS);
                flag_reg[0][k].par_ok <= (s_w >= -ext_sh) && (s_w <= ext_sh);
                for (int j = 0; j < 2; j++) begin
                    r_reg[0][2*k+j]   <= r_next[0][2*k+j];
                    q_reg[0][2*k+j]   <= q_next[0][2*k+j];
                    ud_reg[0][2*k+j]  <= ud;
                    sat_reg[0][2*k+j] <= {1'b0, r_next[0][2*k+j]} >= {ud, 1'b0};
                end
                neg_reg[0][2*k]   <= (s_w > -ext_sh) ^ d_w[NUM_W-1];
                neg_reg[0][2*k+1] <= (s_w > ext_sh) ^ d_w[NUM_W-1];
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 1; i <= LAST; i++) begin : g_step
        always_comb begin
            logic [MAG_W:0] r2;
            for (int l = 0; l < NUM_LANES; l++) begin
                r2 = (i == 1) ? {1'b0, r_reg[i-1][l]} : {r_reg[i-1][l], 1'b0};
                if (r2 >= {1'b0, ud_reg[i-1][l]}) begin
                    r_next[i][l] = MAG_W'(r2 - {1'b0, ud_reg[i-1][l]});
                    q_next[i][l] = {q_reg[i-1][l][Q_W-2:0], 1'b1};
                end else begin
                    r_next[i][l] = MAG_W'(r2);
                    q_next[i][l] = {q_reg[i-1][l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[i]) begin
                flag_reg[i] <= flag_reg[i-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_reg[i][l]   <= r_next[i][l];
                    q_reg[i][l]   <= q_next[i][l];
                    ud_reg[i][l]  <= ud_reg[i-1][l];
                    neg_reg[i][l] <= neg_reg[i-1][l];
                    sat_reg[i][l] <= sat_reg[i-1][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            out_quot[l].neg = neg_reg[LAST][l];
            out_quot[l].sat = sat_reg[LAST][l];
            out_quot[l].q   = q_reg[LAST][l];
        end
        out_flag = flag_reg[LAST];
    end

endmodule

// File: rtl/core/sobb_merge.sv
module sobb_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sobb_pkg::quot_t [5:0]         in_quot,
    input  sobb_pkg::slab_flag_t [2:0]    in_flag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_hit
);
    import sobb_pkg::*;

    logic                     va_reg, vb_reg;
    logic                     adv_a, adv_b;
    logic signed [TIME_W-1:0] lo_reg [NUM_AXES];
    logic signed [TIME_W-1:0] hi_reg [NUM_AXES];
    slab_flag_t [2:0]         flag_reg;
    logic                     hit_reg;
    logic                     hit_next;
    logic signed [TIME_W-1:0] t_next [NUM_LANES];

    assign adv_b     = !vb_reg || out_ready;
    assign adv_a     = !va_reg || adv_b;
    assign in_ready  = adv_a;
    assign out_valid = vb_reg;
    assign out_hit   = hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (adv_a) va_reg <= in_valid;
            if (adv_b) vb_reg <= va_reg;
        end
    end

    always_comb begin
        logic [Q_W-1:0] qe;
        for (int l = 0; l < NUM_LANES; l++) begin
            qe = in_quot[l].sat ? TIME_SAT_Q : in_quot[l].q;
            t_next[l] = in_quot[l].neg ? -$signed({1'b0, qe}) : $signed({1'b0, qe});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            flag_reg <= in_flag;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (t_next[2*k] > t_next[2*k+1]) begin
                    lo_reg[k] <= t_next[2*k+1];
                    hi_reg[k] <= t_next[2*k];
                end else begin
                    lo_reg[k] <= t_next[2*k];
                    hi_reg[k] <= t_next[2*k+1];
                end
            end
        end
    end

    // narrow [0,1] over the slabs that are not parallel; a parallel slab must contain the start point
    always_comb begin
        logic signed [TIME_W-1:0] t_min;
        logic signed [TIME_W-1:0] t_max;
        logic                     ok;
        t_min = '0;
        t_max = TIME_ONE;
        ok    = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            if (flag_reg[k].par) begin
                ok = ok && flag_reg[k].par_ok;
            end else begin
                if (lo_reg[k] > t_min) t_min = lo_reg[k];
                if (hi_reg[k] < t_max) t_max = hi_reg[k];
            end
        end
        hit_next = ok && (t_min <= t_max) && (t_max >= 0) && (t_min <= TIME_ONE);
    end

    always_ff @(posedge aclk) begin
        if (adv_b) hit_reg <= hit_next;
    end

endmodule

// File: rtl/core/sobb_checker.sv
module sobb_sva (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("output padding not zero");

    // input only backs up once every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

bind segment_obb_slab_test_core sobb_sva u_sobb_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
